@@ sv/ssta_pkg.sv @@
// Package for the sorted sparse term accumulator.
// Holds port widths, parameter defaults and the mode, status, state and phase codes.
// Depends on nothing.
package ssta_pkg;

   localparam int MAX_TERMS_DEF   = 16;
   localparam int DEGREE_BITS_DEF = 10;
   localparam int COEFF_BITS_DEF  = 32;

   localparam int MODE_W       = 2;
   localparam int STATUS_W     = 3;
   localparam int DEG_PORT_W   = 10;
   localparam int COEFF_PORT_W = 32;
   localparam int COUNT_PORT_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DUMP   = 2'd1,
      MODE_CLEAR  = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_MERGED   = 3'd1,
      ST_REMOVED  = 3'd2,
      ST_NONE     = 3'd3,
      ST_DROPPED  = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_SCAN    = 5'b00010,
      S_DUMP_RD = 5'b00100,
      S_DUMP_LD = 5'b01000,
      S_RESP    = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      PH_FIND = 3'b001,
      PH_UP   = 3'b010,
      PH_DOWN = 3'b100
   } phase_type;

endpackage

@@ sv/ssta_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the term table of the accumulator. No dependencies.
module ssta_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sorted_sparse_term_accumulator.sv @@
// Sorted sparse term accumulator: a polynomial table kept in ascending degree order.
// Insert: accept, then scan the table (one RAM read a cycle; a merge, or a drop on a full table,
// stops at its entry), then load the result word. Dump: accept, then read and load each term.
// Clear, zero insert, empty dump: accept, then load the result.
// One item at a time; the next item is accepted once the previous one is done.
// Synchronous active-high reset empties the table; table contents stay undefined.
module sorted_sparse_term_accumulator
   import ssta_pkg::*;
#(
   parameter int MAX_TERMS   = MAX_TERMS_DEF,
   parameter int DEGREE_BITS = DEGREE_BITS_DEF,
   parameter int COEFF_BITS  = COEFF_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [MODE_W-1:0]              req_mode,
   input  logic [DEG_PORT_W-1:0]          req_in_degree,
   input  logic signed [COEFF_PORT_W-1:0] req_in_coeff,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic                           rsp_term_valid,
   output logic [DEG_PORT_W-1:0]          rsp_term_degree,
   output logic signed [COEFF_PORT_W-1:0] rsp_term_coeff,
   output logic [COUNT_PORT_W-1:0]        rsp_term_count,
   output logic                           rsp_last
);

   localparam int CNT_W   = $clog2(MAX_TERMS + 1);
   localparam int IDX_W   = MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1;
   localparam int ENTRY_W = DEGREE_BITS + COEFF_BITS;
   localparam int DEG_W   = DEGREE_BITS > DEG_PORT_W ? DEGREE_BITS : DEG_PORT_W;
   localparam int C_EXT   = COEFF_BITS > COEFF_PORT_W ? COEFF_BITS : COEFF_PORT_W;
   localparam int CNT_EXT = CNT_W > COUNT_PORT_W ? CNT_W : COUNT_PORT_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_TERMS);

   function automatic logic [DEG_PORT_W-1:0] deg_to_port(input logic [DEGREE_BITS-1:0] d);
      logic [DEG_W-1:0] w;
      w = DEG_W'(d);
      return w[DEG_PORT_W-1:0];
   endfunction

   function automatic logic [COEFF_PORT_W-1:0] coeff_to_port(input logic [COEFF_BITS-1:0] c);
      logic [C_EXT-1:0] w;
      w = C_EXT'(c);
      return w[COEFF_PORT_W-1:0];
   endfunction

   function automatic logic [COUNT_PORT_W-1:0] count_to_port(input logic [CNT_W-1:0] n);
      logic [CNT_EXT-1:0] w;
      w = CNT_EXT'(n);
      return w[COUNT_PORT_W-1:0];
   endfunction

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]       proc_idx_ff, proc_idx_in;
   logic                   pend_ff, pend_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [ENTRY_W-1:0]     carry_ff, carry_in;
   logic [DEGREE_BITS-1:0] deg_ff, deg_in;
   logic [COEFF_BITS-1:0]  coeff_ff, coeff_in;

   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic                    res_valid_ff, res_valid_in;
   logic [DEGREE_BITS-1:0]  res_deg_ff, res_deg_in;
   logic [COEFF_BITS-1:0]   res_coeff_ff, res_coeff_in;
   logic [CNT_W-1:0]        res_count_ff, res_count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic                     rsp_term_valid_ff, rsp_term_valid_in;
   logic [DEG_PORT_W-1:0]    rsp_term_degree_ff, rsp_term_degree_in;
   logic [COEFF_PORT_W-1:0]  rsp_term_coeff_ff, rsp_term_coeff_in;
   logic [COUNT_PORT_W-1:0]  rsp_term_count_ff, rsp_term_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                   ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]       ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0]     ram_wr_data, ram_rd_data;
   logic [DEGREE_BITS-1:0] e_deg;
   logic [COEFF_BITS-1:0]  e_coeff, sum;
   logic [DEG_W-1:0]       req_deg_ext;
   logic signed [C_EXT-1:0] req_coeff_ext;
   logic [DEGREE_BITS-1:0] req_deg;
   logic [COEFF_BITS-1:0]  req_coeff;
   logic                   out_free, full;

   assign req_deg_ext   = DEG_W'(req_in_degree);
   assign req_deg       = req_deg_ext[DEGREE_BITS-1:0];
   assign req_coeff_ext = C_EXT'(req_in_coeff);
   assign req_coeff     = req_coeff_ext[COEFF_BITS-1:0];

   assign e_deg    = ram_rd_data[ENTRY_W-1:COEFF_BITS];
   assign e_coeff  = ram_rd_data[COEFF_BITS-1:0];
   assign sum      = e_coeff + coeff_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign full     = (count_ff == FULL_COUNT);

   assign req_ready = (state_ff == S_IDLE);

   ssta_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TERMS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rd_idx_in    = rd_idx_ff;
      proc_idx_in  = rd_idx_ff;
      pend_in      = 1'b0;
      count_in     = count_ff;
      carry_in     = carry_ff;
      deg_in       = deg_ff;
      coeff_in     = coeff_ff;
      res_status_in = res_status_ff;
      res_valid_in  = res_valid_ff;
      res_deg_in    = res_deg_ff;
      res_coeff_in  = res_coeff_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_status_in      = rsp_status_ff;
      rsp_term_valid_in  = rsp_term_valid_ff;
      rsp_term_degree_in = rsp_term_degree_ff;
      rsp_term_coeff_in  = rsp_term_coeff_ff;
      rsp_term_count_in  = rsp_term_count_ff;
      rsp_last_in        = rsp_last_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               deg_in        = req_deg;
               coeff_in      = req_coeff;
               rd_idx_in     = '0;
               phase_in      = PH_FIND;
               res_status_in = ST_NONE;
               res_valid_in  = 1'b0;
               res_deg_in    = '0;
               res_coeff_in  = '0;
               res_count_in  = count_ff;
               state_in      = S_RESP;
               unique case (mode_type'(req_mode))
                  MODE_INSERT: begin
                     if (req_coeff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  MODE_DUMP: begin
                     if (count_ff != '0) begin
                        state_in = S_DUMP_RD;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in     = '0;
                     res_count_in = '0;
                  end
                  default: ;
               endcase
            end
         end

         S_SCAN: begin
            // read ahead one entry a cycle; every entry is read before it is rewritten
            if (rd_idx_ff < count_ff) begin
               ram_rd_en = 1'b1;
               rd_idx_in = rd_idx_ff + CNT_W'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               unique case (phase_ff)
                  PH_FIND: begin
                     if (e_deg == deg_ff) begin
                        if (sum != '0) begin
                           ram_wr_en     = 1'b1;
                           ram_wr_addr   = proc_idx_ff[IDX_W-1:0];
                           ram_wr_data   = {deg_ff, sum};
                           res_status_in = ST_MERGED;
                           res_valid_in  = 1'b1;
                           res_deg_in    = deg_ff;
                           res_coeff_in  = sum;
                           res_count_in  = count_ff;
                           state_in      = S_RESP;
                        end else begin
                           phase_in = PH_DOWN;
                        end
                     end else if (e_deg > deg_ff) begin
                        if (full) begin
                           res_status_in = ST_DROPPED;
                           res_valid_in  = 1'b0;
                           res_deg_in    = deg_ff;
                           res_coeff_in  = coeff_ff;
                           res_count_in  = count_ff;
                           state_in      = S_RESP;
                        end else begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = proc_idx_ff[IDX_W-1:0];
                           ram_wr_data = {deg_ff, coeff_ff};
                           carry_in    = ram_rd_data;
                           phase_in    = PH_UP;
                        end
                     end
                  end
                  PH_UP: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = proc_idx_ff[IDX_W-1:0];
                     ram_wr_data = carry_ff;
                     carry_in    = ram_rd_data;
                  end
                  PH_DOWN: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = IDX_W'(proc_idx_ff - CNT_W'(1));
                     ram_wr_data = ram_rd_data;
                  end
                  default: ;
               endcase
            end else if (rd_idx_ff == count_ff) begin
               // all entries seen: append, close the shift, or drop
               state_in     = S_RESP;
               res_deg_in   = deg_ff;
               res_count_in = count_ff;
               unique case (phase_ff)
                  PH_FIND: begin
                     if (full) begin
                        res_status_in = ST_DROPPED;
                        res_valid_in  = 1'b0;
                        res_coeff_in  = coeff_ff;
                     end else begin
                        ram_wr_en     = 1'b1;
                        ram_wr_addr   = count_ff[IDX_W-1:0];
                        ram_wr_data   = {deg_ff, coeff_ff};
                        count_in      = count_ff + CNT_W'(1);
                        res_status_in = ST_INSERTED;
                        res_valid_in  = 1'b1;
                        res_coeff_in  = coeff_ff;
                        res_count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  PH_UP: begin
                     ram_wr_en     = 1'b1;
                     ram_wr_addr   = count_ff[IDX_W-1:0];
                     ram_wr_data   = carry_ff;
                     count_in      = count_ff + CNT_W'(1);
                     res_status_in = ST_INSERTED;
                     res_valid_in  = 1'b1;
                     res_coeff_in  = coeff_ff;
                     res_count_in  = count_ff + CNT_W'(1);
                  end
                  PH_DOWN: begin
                     count_in      = count_ff - CNT_W'(1);
                     res_status_in = ST_REMOVED;
                     res_valid_in  = 1'b0;
                     res_coeff_in  = '0;
                     res_count_in  = count_ff - CNT_W'(1);
                  end
                  default: ;
               endcase
            end
         end

         S_DUMP_RD: begin
            // issue the read only when the output word will be empty next cycle
            if (out_free) begin
               ram_rd_en = 1'b1;
               state_in  = S_DUMP_LD;
            end
         end

         S_DUMP_LD: begin
            rsp_valid_in       = 1'b1;
            rsp_status_in      = ST_NONE;
            rsp_term_valid_in  = 1'b1;
            rsp_term_degree_in = deg_to_port(e_deg);
            rsp_term_coeff_in  = coeff_to_port(e_coeff);
            rsp_term_count_in  = count_to_port(count_ff);
            rsp_last_in        = ((rd_idx_ff + CNT_W'(1)) == count_ff);
            rd_idx_in          = rd_idx_ff + CNT_W'(1);
            state_in           = ((rd_idx_ff + CNT_W'(1)) == count_ff) ? S_IDLE : S_DUMP_RD;
         end

         S_RESP: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = res_status_ff;
               rsp_term_valid_in  = res_valid_ff;
               rsp_term_degree_in = deg_to_port(res_deg_ff);
               rsp_term_coeff_in  = coeff_to_port(res_coeff_ff);
               rsp_term_count_in  = count_to_port(res_count_ff);
               rsp_last_in        = 1'b1;
               state_in           = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_FIND;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff          <= rd_idx_in;
      proc_idx_ff        <= proc_idx_in;
      carry_ff           <= carry_in;
      deg_ff             <= deg_in;
      coeff_ff           <= coeff_in;
      res_status_ff      <= res_status_in;
      res_valid_ff       <= res_valid_in;
      res_deg_ff         <= res_deg_in;
      res_coeff_ff       <= res_coeff_in;
      res_count_ff       <= res_count_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_term_valid_ff  <= rsp_term_valid_in;
      rsp_term_degree_ff <= rsp_term_degree_in;
      rsp_term_coeff_ff  <= rsp_term_coeff_in;
      rsp_term_count_ff  <= rsp_term_count_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_term_valid  = rsp_term_valid_ff;
   assign rsp_term_degree = rsp_term_degree_ff;
   assign rsp_term_coeff  = rsp_term_coeff_ff;
   assign rsp_term_count  = rsp_term_count_ff;
   assign rsp_last        = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("term count above table depth");

   a_dump_load_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP_LD |-> !rsp_valid_ff)
      else $error("dump word loaded over a pending word");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |->
         ($past(state_ff) == S_RESP || $past(state_ff) == S_DUMP_LD))
      else $error("result word raised outside a load state");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && count_ff != $past(count_ff) |->
         ($past(state_ff) == S_SCAN || $past(state_ff) == S_IDLE))
      else $error("term count changed outside insert or clear");

endmodule
